// File: design/ple_pkg.sv
// Package for the positional list engine: sizes, command and status codes,
// the token that travels down the cell chain and the result record.
// No dependencies.
`default_nettype none

package ple_pkg;

  // List capacity (number of cells in the chain)
  localparam int unsigned CAPACITY = 256;

  // Internal length / index / count width: must hold CAPACITY itself
  localparam int unsigned LenW = $clog2(CAPACITY + 1);

  // Fixed field widths of the item ports
  localparam int unsigned CmdW    = 3;
  localparam int unsigned PosW    = 9;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StW     = 2;
  localparam int unsigned CntOutW = 9;
  localparam int unsigned LenOutW = 9;

  // Width used to compare a requested position against the length
  localparam int unsigned CmpW = (LenW > PosW) ? LenW : PosW;

  // Command codes
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CmdW-1:0] CMD_APPEND = 3'd1;
  localparam logic [CmdW-1:0] CMD_INSERT = 3'd2;
  localparam logic [CmdW-1:0] CMD_DELETE = 3'd3;
  localparam logic [CmdW-1:0] CMD_COUNT  = 3'd4;

  // Status codes
  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_RANGE = 2'd1;
  localparam logic [StW-1:0] ST_FULL  = 2'd2;

  // Operation a token performs as it passes each cell
  typedef enum logic [1:0] {
    OP_NOP,
    OP_INS,
    OP_DEL,
    OP_CNT
  } ple_op_e;

  typedef struct packed {
    logic            vld;
    ple_op_e         op;
    logic [LenW-1:0] idx;   // first cell touched by insert / delete
    logic [LenW-1:0] len;   // list length before the command
    logic [ValW-1:0] data;  // value carried: shifted entry, removed or searched
    logic [LenW-1:0] cnt;   // running match count
  } ple_tok_t;

  typedef struct packed {
    logic [StW-1:0]     status;
    logic [ValW-1:0]    removed;
    logic [CntOutW-1:0] match_cnt;
    logic [LenOutW-1:0] length;
  } ple_res_t;

endpackage

`default_nettype wire

// File: design/positional_list_engine.sv
// Positional list engine top level: command decode, a chain of CAPACITY list
// cells, and the result registers. Depends on ple_pkg and ple_cell.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values and
// runs one command per item: clear, append, insert after a given number of
// entries, delete at a 1-based position (returning the value), or count the
// entries equal to a value. Each item yields exactly one result carrying a
// status (ok, position out of range, list full), the removed value, the
// match count and the list length after the command. Status and the new
// length are decided when the item is accepted; the command then travels as
// a token down a chain of CAPACITY cells, one cell per clock, each cell
// shifting, capturing or comparing its own entry. One item is in flight at a
// time: the result is registered in the output stage as its token leaves the
// last cell, and the next item can be accepted once that token has left the
// chain, so throughput is set by the length of the cell chain.
// A finished result waits in the output register without blocking the next
// item; a second result parks in one pending slot behind it and holds the
// input off until it moves up.
// Clear only zeroes the length; entry contents are left in place and entries
// beyond the length are never reported.
`default_nettype none

module positional_list_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command items
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ple_pkg::CmdW-1:0]    command_i,
  input  wire logic [ple_pkg::PosW-1:0]    position_i,
  input  wire logic signed [ple_pkg::ValW-1:0] value_i,
  // result items
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ple_pkg::StW-1:0]          status_o,
  output logic signed [ple_pkg::ValW-1:0]  removed_value_o,
  output logic [ple_pkg::CntOutW-1:0]      match_count_o,
  output logic [ple_pkg::LenOutW-1:0]      list_length_o
);
  import ple_pkg::*;

  // ---------------------------------------------------------------------
  // Architectural length and command decode
  // ---------------------------------------------------------------------
  logic [LenW-1:0] len_d, len_q;
  logic [StW-1:0]  st_d, st_q;
  logic            busy_d, busy_q;
  logic            in_fire;
  ple_tok_t        head_tok;

  logic [CmpW-1:0] pos_cmp, len_cmp;
  logic            is_full;

  assign in_fire = in_valid_i && in_ready_o;
  assign pos_cmp = CmpW'(position_i);
  assign len_cmp = CmpW'(len_q);
  assign is_full = (len_q >= LenW'(CAPACITY));

  always_comb begin
    len_d         = len_q;
    st_d          = ST_OK;
    head_tok      = '0;
    head_tok.vld  = in_fire;
    head_tok.op   = OP_NOP;
    head_tok.len  = len_q;
    head_tok.data = '0;
    case (command_i)
      CMD_CLEAR: begin
        len_d = '0;
      end
      CMD_APPEND: begin
        if (is_full) begin
          st_d = ST_FULL;
        end else begin
          head_tok.op   = OP_INS;
          head_tok.idx  = len_q;
          head_tok.data = value_i;
          len_d         = len_q + LenW'(1);
        end
      end
      CMD_INSERT: begin
        // range check comes before the full check
        if (pos_cmp > len_cmp) begin
          st_d = ST_RANGE;
        end else if (is_full) begin
          st_d = ST_FULL;
        end else begin
          head_tok.op   = OP_INS;
          head_tok.idx  = LenW'(position_i);
          head_tok.data = value_i;
          len_d         = len_q + LenW'(1);
        end
      end
      CMD_DELETE: begin
        if ((position_i == '0) || (pos_cmp > len_cmp)) begin
          st_d = ST_RANGE;
        end else begin
          head_tok.op  = OP_DEL;
          head_tok.idx = LenW'(position_i - PosW'(1));
          len_d        = len_q - LenW'(1);
        end
      end
      CMD_COUNT: begin
        head_tok.op   = OP_CNT;
        head_tok.data = value_i;
      end
      default: begin
        // unused codes: nothing changes
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Cell chain: tok[k] enters cell k, tok[CAPACITY] leaves the last cell
  // ---------------------------------------------------------------------
  ple_tok_t        tok   [CAPACITY+1];
  logic [ValW-1:0] entry [CAPACITY];

  assign tok[0] = head_tok;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ValW-1:0] nbr;
    if (g == CAPACITY - 1) begin : g_last
      // nothing beyond the end: hold own entry on delete
      assign nbr = entry[g];
    end else begin : g_mid
      assign nbr = entry[g+1];
    end

    ple_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (LenW'(g)),
      .tok_i   (tok[g]),
      .nbr_i   (nbr),
      .tok_o   (tok[g+1]),
      .entry_o (entry[g])
    );
  end

  ple_tok_t tail;
  logic     tok_exit;

  assign tail     = tok[CAPACITY];
  assign tok_exit = tail.vld;

  // ---------------------------------------------------------------------
  // Result assembly, output register and one pending slot
  // ---------------------------------------------------------------------
  ple_res_t exit_res;
  ple_res_t out_d, out_q, pend_d, pend_q;
  logic     out_vld_d, out_vld_q, pend_vld_d, pend_vld_q;
  logic     out_fire;

  always_comb begin
    exit_res.status    = st_q;
    exit_res.removed   = (tail.op == OP_DEL) ? tail.data : '0;
    exit_res.match_cnt = (tail.op == OP_CNT) ? CntOutW'(tail.cnt) : '0;
    exit_res.length    = LenOutW'(len_q);
  end

  assign out_fire = out_vld_q && out_ready_i;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    busy_d     = busy_q;

    if (out_fire) begin
      out_vld_d = 1'b0;
    end

    if (tok_exit) begin
      busy_d = 1'b0;
      if (!out_vld_q || out_fire) begin
        out_d     = exit_res;
        out_vld_d = 1'b1;
      end else begin
        // output still occupied: park the result
        pend_d     = exit_res;
        pend_vld_d = 1'b1;
      end
    end else if (out_fire && pend_vld_q) begin
      out_d      = pend_q;
      out_vld_d  = 1'b1;
      pend_vld_d = 1'b0;
    end

    if (in_fire) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      st_q       <= ST_OK;
      busy_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        len_q <= len_d;
        st_q  <= st_d;
      end
      busy_q     <= busy_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  // Accept a new item only with the chain empty and no parked result
  assign in_ready_o      = !busy_q && !pend_vld_q;
  assign out_valid_o     = out_vld_q;
  assign status_o        = out_q.status;
  assign removed_value_o = out_q.removed;
  assign match_count_o   = out_q.match_cnt;
  assign list_length_o   = out_q.length;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> out_vld_q)
    else $error("pending result without an occupied output register");

  a_exit_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_exit |-> busy_q)
    else $error("token left the chain while no item was in flight");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_accept_starts_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (tok[1].vld && busy_q))
    else $error("accepted item did not enter the cell chain");

endmodule

`default_nettype wire

// File: design/ple_cell.sv
// One list cell: holds one entry and processes the token passing through it.
// Depends on ple_pkg.
`default_nettype none

module ple_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [ple_pkg::LenW-1:0] idx_i,    // this cell's position
  input  wire ple_pkg::ple_tok_t        tok_i,
  input  wire logic [ple_pkg::ValW-1:0] nbr_i,    // entry of the next cell
  output ple_pkg::ple_tok_t             tok_o,
  output logic [ple_pkg::ValW-1:0]      entry_o
);
  import ple_pkg::*;

  ple_tok_t        tok_d, tok_q;
  logic [ValW-1:0] entry_d, entry_q;

  always_comb begin
    tok_d   = tok_i;
    entry_d = entry_q;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_INS: begin
          // take the carried value, pass the old entry on
          if (idx_i >= tok_i.idx) begin
            entry_d    = tok_i.data;
            tok_d.data = entry_q;
          end
        end
        OP_DEL: begin
          // pull the neighbor's entry in, capture the removed one
          if (idx_i >= tok_i.idx) begin
            entry_d = nbr_i;
          end
          if (idx_i == tok_i.idx) begin
            tok_d.data = entry_q;
          end
        end
        OP_CNT: begin
          if ((idx_i < tok_i.len) && (entry_q == tok_i.data)) begin
            tok_d.cnt = tok_i.cnt + LenW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: test/positional_list_engine_test.sv
// Testbench for positional_list_engine: drives command items, predicts each
// result from a shadow copy of the list, and checks every result field.
// Depends on ple_pkg and the positional_list_engine RTL.

module positional_list_engine_test;
  import ple_pkg::*;

  // Watchdog bound, far above the slowest legal run of this stimulus
  localparam int unsigned CYCLE_LIMIT = 2_500_000;
  // First command code with no meaning; codes up to all ones are ignored
  localparam int unsigned CMD_UNUSED_LO = CMD_COUNT + 1;
  localparam int unsigned CMD_UNUSED_HI = (1 << CmdW) - 1;
  localparam int unsigned MAX_SHOWN = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i;
  logic [PosW-1:0]     position_i;
  logic [ValW-1:0]     value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [StW-1:0]      status_o;
  logic [ValW-1:0]     removed_value_o;
  logic [CntOutW-1:0]  match_count_o;
  logic [LenOutW-1:0]  list_length_o;

  // Shadow of the list held by the block
  logic [ValW-1:0] shadow_entries [CAPACITY];
  int              shadow_len;

  ple_res_t predicted_results [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_left;
  int mismatches;
  int results_seen;
  int cycle_count;

  positional_list_engine DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .match_count_o   (match_count_o),
    .list_length_o   (list_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the shadow list and return the result it must give.
  function automatic ple_res_t run_list_command(logic [CmdW-1:0] cmd,
                                                logic [PosW-1:0] pos,
                                                logic [ValW-1:0] val);
    ple_res_t r;
    int       ins_at;
    int       hits;
    r = '0;
    r.status = ST_OK;
    hits = 0;
    case (cmd)
      CMD_CLEAR: begin
        // Entries stay in place; only the length goes to zero
        shadow_len = 0;
      end
      CMD_APPEND, CMD_INSERT: begin
        ins_at = (cmd == CMD_APPEND) ? shadow_len : int'(pos);
        // Range check wins over the full check
        if (ins_at > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > ins_at; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[ins_at] = val;
          shadow_len++;
        end
      end
      CMD_DELETE: begin
        if (pos == 0 || int'(pos) > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.removed = shadow_entries[pos-1];
          for (int i = int'(pos) - 1; i + 1 < shadow_len; i++) begin
            shadow_entries[i] = shadow_entries[i+1];
          end
          shadow_len--;
        end
      end
      CMD_COUNT: begin
        for (int i = 0; i < shadow_len; i++) if (shadow_entries[i] == val) hits++;
      end
      default: begin
      end
    endcase
    r.match_cnt = CntOutW'(hits);
    r.length    = LenOutW'(shadow_len);
    return r;
  endfunction

  // Offer one item, hold it until taken, then record its expected result.
  task automatic send_item(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                           logic [ValW-1:0] val);
    int gap;
    bit taken;
    gap = 0;
    if (sender_idle_pct > 0) begin
      while (gap < 64 && $urandom_range(99) < sender_idle_pct) gap++;
      // Now and then idle long enough to land anywhere in the chain pass
      if ($urandom_range(11) == 0) gap += $urandom_range(1, CAPACITY + 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= val;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    predicted_results.push_back(run_list_command(cmd, pos, val));
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed commands with in-range positions; the rest is noise.
  task automatic send_random_item();
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    int              pick;
    int              grow;
    pick = $urandom_range(99);
    // Keep the length hovering near a few dozen so deletes find entries
    grow = (shadow_len < 32) ? 55 : 30;
    pos  = PosW'($urandom());
    if ($urandom_range(2) != 0) val = ValW'($urandom_range(0, 6) - 3);
    else val = $urandom();
    if (pick < 2) begin
      cmd = CMD_CLEAR;
    end else if (pick < 5) begin
      cmd = CmdW'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    end else if (pick < 5 + grow) begin
      if ($urandom_range(1) != 0) begin
        cmd = CMD_APPEND;
      end else begin
        cmd = CMD_INSERT;
        if ($urandom_range(9) != 0) pos = PosW'($urandom_range(0, shadow_len));
      end
    end else if (pick < 85) begin
      cmd = CMD_DELETE;
      if (shadow_len > 0 && $urandom_range(9) != 0) pos = PosW'($urandom_range(1, shadow_len));
    end else begin
      cmd = CMD_COUNT;
      if (shadow_len > 0 && $urandom_range(1) != 0) begin
        val = shadow_entries[$urandom_range(0, shadow_len - 1)];
      end
    end
    send_item(cmd, pos, val);
  endtask

  // Edge cases on a short list: empty list, value extremes, both ends,
  // out-of-range positions, unused codes, and clear leaving entries behind.
  task automatic test_directed_edges();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_item(CMD_COUNT, '0, '0);
    send_item(CMD_DELETE, PosW'(1), '0);
    send_item(CMD_DELETE, '0, '0);
    send_item(CMD_INSERT, PosW'(1), '1);
    send_item(CMD_INSERT, '0, {1'b1, {(ValW-1){1'b0}}});
    send_item(CMD_APPEND, '1, {1'b0, {(ValW-1){1'b1}}});
    send_item(CMD_APPEND, '0, '1);
    send_item(CMD_INSERT, PosW'(3), '0);
    send_item(CMD_INSERT, PosW'(1), 32'h1234_5678);
    send_item(CMD_COUNT, '0, '0);
    send_item(CMD_COUNT, '0, {1'b1, {(ValW-1){1'b0}}});
    send_item(CMD_INSERT, '1, '0);
    send_item(CMD_DELETE, '1, '0);
    send_item(CMD_DELETE, PosW'(5), '0);
    send_item(CMD_DELETE, PosW'(1), '0);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      send_item(CmdW'(c), PosW'($urandom()), $urandom());
    end
    send_item(CMD_COUNT, '0, '1);
    send_item(CMD_CLEAR, PosW'($urandom()), $urandom());
    send_item(CMD_COUNT, '0, '1);
    send_item(CMD_APPEND, '0, 32'hDEAD_BEEF);
    send_item(CMD_COUNT, '0, 32'hDEAD_BEEF);
    send_item(CMD_DELETE, PosW'(1), '0);
    drain_results();
  endtask

  // Fill the list to capacity, then hit the full and range checks there.
  task automatic test_fill_to_capacity();
    logic [ValW-1:0] filler;
    logic [ValW-1:0] odd_one;
    int              odd_at;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    filler  = $urandom();
    odd_one = ~filler;
    odd_at  = $urandom_range(0, CAPACITY - 1);
    send_item(CMD_CLEAR, '0, '0);
    repeat (CAPACITY - 1) send_item(CMD_APPEND, PosW'($urandom()), filler);
    send_item(CMD_INSERT, PosW'(odd_at), odd_one);
    send_item(CMD_COUNT, '0, filler);
    send_item(CMD_APPEND, '0, filler);
    send_item(CMD_INSERT, PosW'(CAPACITY), filler);
    // Position past the length reports range even on a full list
    send_item(CMD_INSERT, PosW'(CAPACITY + 1), filler);
    send_item(CMD_DELETE, PosW'(odd_at + 1), '0);
    send_item(CMD_APPEND, '0, filler);
    send_item(CMD_COUNT, '0, filler);
    send_item(CMD_DELETE, PosW'(CAPACITY + 1), '0);
    send_item(CMD_DELETE, PosW'(CAPACITY), '0);
    send_item(CMD_CLEAR, '0, '0);
    drain_results();
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the output stage backs up and the input stalls.
  task automatic test_backpressure();
    drain_results();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    @(negedge clk_i);
    hold_off_left = 6 * (CAPACITY + 1);
    @(posedge clk_i);
    repeat (8) send_random_item();
    drain_results();
  endtask

  task automatic test_random_phase(int items, int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (items) send_random_item();
    drain_results();
  endtask

  // Receiver: forced hold-off first, otherwise random stalls.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Sample at the falling edge: a result seen here is taken at the next rise.
  always @(negedge clk_i) begin
    ple_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("result %0d arrived with nothing outstanding", results_seen);
        end
      end else begin
        want = predicted_results.pop_front();
        if (status_o !== want.status || removed_value_o !== want.removed ||
            match_count_o !== want.match_cnt || list_length_o !== want.length) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("result %0d: expected status %0d removed %0d matches %0d length %0d",
                     results_seen, want.status, $signed(want.removed), want.match_cnt,
                     want.length);
            $display("result %0d: got      status %0d removed %0d matches %0d length %0d",
                     results_seen, status_o, $signed(removed_value_o), match_count_o,
                     list_length_o);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    command_i          = '0;
    position_i         = '0;
    value_i            = '0;
    shadow_len         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_left      = 0;
    mismatches         = 0;
    results_seen       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_fill_to_capacity();
    test_random_phase(190, 0, 0);
    test_random_phase(190, 85, 0);
    test_backpressure();
    test_random_phase(190, 0, 85);
    test_random_phase(190, 32, 32);

    drain_results();
    // Let any stray result make it through the chain before deciding
    repeat (CAPACITY + 16) @(posedge clk_i);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
